@@ rtl/fpba_pkg.sv @@
package fpba_pkg;

    localparam int NUM_BLOCKS_DEF = 16;

    localparam int SLOT_W = 4;
    localparam int SIZE_W = 16;
    localparam int POL_W  = 2;
    localparam int BIU_W  = 5;
    localparam int CFG_W  = 5;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [POL_W-1:0]  pol_t;
    typedef logic [BIU_W-1:0]  biu_t;
    typedef logic [CFG_W-1:0]  cfg_data_t;
    typedef logic              cfg_idx_t;

    // register indexes
    localparam cfg_idx_t REG_FIT_POLICY    = 1'b0;
    localparam cfg_idx_t REG_BLOCKS_IN_USE = 1'b1;

    // policy codes; the unused code behaves as first fit
    localparam pol_t POL_FIRST = 2'd0;
    localparam pol_t POL_BEST  = 2'd1;
    localparam pol_t POL_WORST = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_REQ  = 1'b1;

    localparam pol_t POL_RESET = POL_FIRST;
    localparam biu_t BIU_RESET = 5'd16;

    typedef struct packed {
        logic load_wr;
        logic start;
        logic scan_en;
        logic wb_en;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
    } dp_sts_t;

endpackage

@@ rtl/fpba_ctrl.sv @@
module fpba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              cmd,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output fpba_pkg::dp_cmd_t dp_cmd,
    input  fpba_pkg::dp_sts_t dp_sts
);
    import fpba_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WB,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_vld_reg;
    logic   out_vld_next;
    logic   accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        dp_cmd.load_wr  = accept && (cmd == CMD_LOAD);
        dp_cmd.start    = accept && (cmd == CMD_REQ);
        dp_cmd.scan_en  = (state_reg == ST_SCAN);
        dp_cmd.wb_en    = (state_reg == ST_WB);
        dp_cmd.out_load = (state_reg == ST_DONE) && (!out_vld_reg || !out_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (dp_cmd.start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (dp_sts.scan_done)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (dp_cmd.out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
        if (dp_cmd.out_load)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_vld_reg;

endmodule

@@ rtl/fpba_dp.sv @@
module fpba_dp #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  fpba_pkg::cfg_idx_t  cfg_index,
    input  fpba_pkg::cfg_data_t cfg_data,
    input  fpba_pkg::slot_t     block_slot,
    input  fpba_pkg::size_t     size_value,
    input  logic                last_request,
    output logic                found,
    output fpba_pkg::slot_t     chosen_block,
    output fpba_pkg::size_t     remaining_after,
    output logic                batch_end,
    input  fpba_pkg::dp_cmd_t   dp_cmd,
    output fpba_pkg::dp_sts_t   dp_sts
);
    import fpba_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int LIM_W = (CNT_W > BIU_W) ? CNT_W : BIU_W;
    localparam logic [LIM_W-1:0] NUM_LIM = LIM_W'(NUM_BLOCKS);

    size_t free_mem [NUM_BLOCKS];

    pol_t              pol_reg;
    biu_t              biu_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [LIM_W-1:0]  cnt_reg;
    size_t             req_size_reg;
    logic              last_reg;
    size_t             rd_data_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              have_reg;
    logic [IDX_W-1:0]  pick_reg;
    size_t             best_reg;
    logic              found_reg;
    slot_t             chosen_reg;
    size_t             remain_reg;
    logic              batch_end_reg;

    logic [LIM_W-1:0]  biu_ext;
    logic [LIM_W-1:0]  limit_next;
    logic [LIM_W-1:0]  slot_ext;
    logic [LIM_W-1:0]  pick_ext;
    logic              issue;
    logic              fits;
    logic              take;
    size_t             left;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    size_t             wr_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pol_reg <= POL_RESET;
            biu_reg <= BIU_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FIT_POLICY:    pol_reg <= cfg_data[POL_W-1:0];
                REG_BLOCKS_IN_USE: biu_reg <= cfg_data[BIU_W-1:0];
            endcase
        end
    end

    assign biu_ext    = LIM_W'(biu_reg);
    assign limit_next = (biu_ext > NUM_LIM) ? NUM_LIM : biu_ext;
    assign slot_ext   = LIM_W'(block_slot);
    assign pick_ext   = LIM_W'(pick_reg);

    assign issue = dp_cmd.scan_en && (cnt_reg < limit_reg);
    assign fits  = cmp_vld_reg && (rd_data_reg >= req_size_reg);

    always_comb
    begin
        take = 1'b0;
        if (fits)
        begin
            if (!have_reg)
            begin
                take = 1'b1;
            end
            else
            begin
                case (pol_reg)
                    POL_BEST:  take = (rd_data_reg < best_reg);
                    POL_WORST: take = (rd_data_reg > best_reg);
                    default:   take = 1'b0;
                endcase
            end
        end
    end

    assign left = best_reg - req_size_reg;

    assign dp_sts.scan_done = (cnt_reg >= limit_reg) && !cmp_vld_reg;

    // scan control and running pick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            limit_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            have_reg    <= 1'b0;
        end
        else if (dp_cmd.start)
        begin
            cnt_reg     <= '0;
            limit_reg   <= limit_next;
            cmp_vld_reg <= 1'b0;
            have_reg    <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= issue;
            if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (take)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.start)
        begin
            req_size_reg <= size_value;
            last_reg     <= last_request;
        end
        if (issue)
        begin
            cmp_idx_reg <= cnt_reg[IDX_W-1:0];
        end
        if (take)
        begin
            pick_reg <= cmp_idx_reg;
            best_reg <= rd_data_reg;
        end
    end

    // free size table: one write port, one registered read port
    assign wr_en   = (dp_cmd.load_wr && (slot_ext < NUM_LIM)) || (dp_cmd.wb_en && have_reg);
    assign wr_addr = dp_cmd.wb_en ? pick_reg : slot_ext[IDX_W-1:0];
    assign wr_data = dp_cmd.wb_en ? left : size_value;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            free_mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= free_mem[cnt_reg[IDX_W-1:0]];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (dp_cmd.out_load)
        begin
            found_reg     <= have_reg;
            chosen_reg    <= have_reg ? pick_ext[SLOT_W-1:0] : '0;
            remain_reg    <= have_reg ? left : '0;
            batch_end_reg <= last_reg;
        end
    end

    assign found           = found_reg;
    assign chosen_block    = chosen_reg;
    assign remaining_after = remain_reg;
    assign batch_end       = batch_end_reg;

endmodule

@@ rtl/fit_policy_block_allocator_unit.sv @@
// Channel  Handshake             Payload
// cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
// in       in_valid/in_stall     cmd, block_slot, size_value, last_request
// out      out_valid/out_stall   found, chosen_block, remaining_after, batch_end
//
// A load item frees the input at once.
// A request holds the input through a scan of blocks_in_use entries (capped at NUM_BLOCKS):
// one table read per entry through the single registered read port, the last compare,
// scan end, write back, result load and the return to idle.
// Reset clears control and configuration; table contents stay undefined until loaded.
// A stalled result holds in the output register; a finished request waits for it.
module fit_policy_block_allocator_unit #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  fpba_pkg::cfg_idx_t  cfg_index,
    input  fpba_pkg::cfg_data_t cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  fpba_pkg::slot_t     block_slot,
    input  fpba_pkg::size_t     size_value,
    input  logic                last_request,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                found,
    output fpba_pkg::slot_t     chosen_block,
    output fpba_pkg::size_t     remaining_after,
    output logic                batch_end
);
    import fpba_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    assign cfg_ready = 1'b1;

    fpba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd),
        .dp_sts    (dp_sts)
    );

    fpba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .block_slot      (block_slot),
        .size_value      (size_value),
        .last_request    (last_request),
        .found           (found),
        .chosen_block    (chosen_block),
        .remaining_after (remaining_after),
        .batch_end       (batch_end),
        .dp_cmd          (dp_cmd),
        .dp_sts          (dp_sts)
    );

endmodule

@@ rtl/fpba_chk.sv @@
module fpba_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                cmd,
    input logic                out_valid,
    input logic                out_stall,
    input logic                found,
    input fpba_pkg::slot_t     chosen_block,
    input fpba_pkg::size_t     remaining_after,
    input logic                batch_end
);
    import fpba_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(chosen_block)
            && $stable(remaining_after) && $stable(batch_end))
        else $error("stalled result changed");

    // a miss reports zero index and zero size
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> chosen_block == '0 && remaining_after == '0)
        else $error("miss result not cleared");

    // a request occupies the input while it scans
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_REQ |=> in_stall)
        else $error("input free right after a request");

    // a load never frees the input late or makes a result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_LOAD |=> !in_stall && !$rose(out_valid))
        else $error("load caused busy or result");

endmodule

bind fit_policy_block_allocator_unit fpba_chk u_fpba_chk (.*);

@@ dv/fpba_alloc_checker.sv @@
`timescale 1ns / 100ps

module fpba_alloc_checker #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  fpba_pkg::cfg_idx_t  cfg_index,
    input  fpba_pkg::cfg_data_t cfg_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                cmd,
    input  fpba_pkg::slot_t     block_slot,
    input  fpba_pkg::size_t     size_value,
    input  logic                last_request,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                found,
    input  fpba_pkg::slot_t     chosen_block,
    input  fpba_pkg::size_t     remaining_after,
    input  logic                batch_end,
    output int                  mismatches,
    output int                  outstanding,
    output int                  hits,
    output int                  misses
);
    import fpba_pkg::*;

    typedef struct packed {
        logic  found;
        slot_t chosen_block;
        size_t remaining_after;
        logic  batch_end;
    } alloc_t;

    size_t  free_left [NUM_BLOCKS];
    pol_t   policy;
    biu_t   scan_count;
    alloc_t pending_allocs [$];
    alloc_t got;
    alloc_t want;

    // Scan the entries in use, pick per policy, take the request out of the winner.
    function automatic alloc_t allocate(size_t ask, logic fin);
        alloc_t r;
        int     span;
        int     pick;
        bit     have;
        span = (int'(scan_count) > NUM_BLOCKS) ? NUM_BLOCKS : int'(scan_count);
        pick = 0;
        have = 1'b0;
        for (int j = 0; j < span; j++)
        begin
            if (free_left[j] >= ask)
            begin
                if (!have)
                begin
                    have = 1'b1;
                    pick = j;
                end
                else if (policy == POL_BEST && free_left[j] < free_left[pick])
                begin
                    pick = j;
                end
                else if (policy == POL_WORST && free_left[j] > free_left[pick])
                begin
                    pick = j;
                end
            end
        end
        r.found           = have;
        r.chosen_block    = have ? slot_t'(pick) : '0;
        r.remaining_after = have ? size_t'(free_left[pick] - ask) : '0;
        r.batch_end       = fin;
        if (have)
        begin
            free_left[pick] = r.remaining_after;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy      = POL_RESET;
            scan_count  = BIU_RESET;
            pending_allocs.delete();
            mismatches  = 0;
            outstanding = 0;
            hits        = 0;
            misses      = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{found, chosen_block, remaining_after, batch_end};
                if (pending_allocs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("[%0t] result with nothing expected: found=%0b block=%0d",
                                 $time, got.found, got.chosen_block,
                                 " left=%0d end=%0b", got.remaining_after, got.batch_end);
                    end
                end
                else
                begin
                    want = pending_allocs.pop_front();
                    if (got.found !== want.found || got.chosen_block !== want.chosen_block ||
                        got.remaining_after !== want.remaining_after ||
                        got.batch_end !== want.batch_end)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("[%0t] allocation mismatch: expected found=%0b block=%0d",
                                     $time, want.found, want.chosen_block,
                                     " left=%0d end=%0b", want.remaining_after, want.batch_end);
                            $display("    got found=%0b block=%0d left=%0d end=%0b",
                                     got.found, got.chosen_block, got.remaining_after,
                                     got.batch_end);
                        end
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FIT_POLICY)
                begin
                    policy = pol_t'(cfg_data[POL_W-1:0]);
                end
                else if (cfg_index == REG_BLOCKS_IN_USE)
                begin
                    scan_count = biu_t'(cfg_data);
                end
            end

            if (in_valid && !in_stall)
            begin
                if (cmd == CMD_LOAD)
                begin
                    if (int'(block_slot) < NUM_BLOCKS)
                    begin
                        free_left[block_slot] = size_value;
                    end
                end
                else
                begin
                    want = allocate(size_value, last_request);
                    if (want.found)
                    begin
                        hits++;
                    end
                    else
                    begin
                        misses++;
                    end
                    pending_allocs.push_back(want);
                end
            end

            outstanding = pending_allocs.size();
        end
    end

endmodule

@@ dv/fit_policy_block_allocator_unit_tb.sv @@
`timescale 1ns / 100ps

module fit_policy_block_allocator_unit_tb;
    import fpba_pkg::*;

    localparam pol_t POL_SPARE   = 2'd3;  // unused code, behaves as first fit
    localparam int   HOLD_CYCLES = 24;
    localparam int   PHASES      = 10;
    localparam int   PHASE_ITEMS = 95;

    logic      clk;
    logic      rst_n;
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;
    logic      in_valid;
    logic      in_stall;
    logic      cmd;
    slot_t     block_slot;
    size_t     size_value;
    logic      last_request;
    logic      out_valid;
    logic      out_stall;
    logic      found;
    slot_t     chosen_block;
    size_t     remaining_after;
    logic      batch_end;

    int mismatches;
    int outstanding;
    int hits;
    int misses;
    int n_loads;
    int n_reqs;
    int n_settings;
    int calm_in;
    int calm_out;

    size_t opening_sizes [16] = '{16'd100, 16'd0, 16'd65535, 16'd500, 16'd300, 16'd500,
                                  16'd1, 16'd2, 16'd40000, 16'd32768, 16'd7, 16'd300,
                                  16'd12, 16'd65534, 16'd1000, 16'd250};
    pol_t      phase_pol [PHASES] = '{POL_BEST, POL_WORST, POL_FIRST, POL_SPARE, POL_BEST,
                                      POL_WORST, POL_FIRST, POL_BEST, POL_WORST, POL_FIRST};
    cfg_data_t phase_cnt [PHASES] = '{5'd16, 5'd1, 5'd16, 5'd4, 5'd31, 5'd8, 5'd2, 5'd12,
                                      5'd17, 5'd16};

    fit_policy_block_allocator_unit uut (.*);

    fpba_alloc_checker alloc_watch (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // Mostly random waits, with the odd stretch of back-to-back items.
    function automatic int pick_wait(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    task automatic send_item(logic op, slot_t slot, size_t sz, logic fin);
        int gap;
        gap = pick_wait(calm_in);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= op;
        block_slot   <= slot;
        size_value   <= sz;
        last_request <= fin;
        do @(posedge clk); while (!(in_valid && !in_stall));
        if (op == CMD_REQ)
        begin
            n_reqs++;
        end
        else
        begin
            n_loads++;
        end
    endtask

    // Hold the input until every outstanding result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic apply_setting(pol_t pol, cfg_data_t cnt);
        wait_drained();
        repeat (HOLD_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FIT_POLICY;
        cfg_data  <= cfg_data_t'(pol);
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_BLOCKS_IN_USE;
        cfg_data  <= cnt;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic send_random_item();
        size_t sz;
        if ($urandom_range(0, 9) < 7)
        begin
            case ($urandom_range(0, 19))
                0:       sz = '0;
                1, 2:    sz = size_t'($urandom);
                3:       sz = '1;
                default: sz = $urandom_range(0, 1) ? size_t'($urandom_range(0, 511))
                                                   : size_t'($urandom_range(0, 4095));
            endcase
            send_item(CMD_REQ, slot_t'($urandom), sz, ($urandom_range(0, 3) == 0));
        end
        else
        begin
            sz = ($urandom_range(0, 3) == 0) ? size_t'($urandom)
                                             : size_t'($urandom_range(0, 4095));
            send_item(CMD_LOAD, slot_t'($urandom), sz, 1'($urandom_range(0, 1)));
        end
    endtask

    // Result side: stall a random number of cycles ahead of each item.
    initial
    begin
        int hold;
        calm_out = 0;
        out_stall <= 1'b0;
        forever
        begin
            hold = pick_wait(calm_out);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_FIT_POLICY;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        cmd          <= CMD_LOAD;
        block_slot   <= '0;
        size_value   <= '0;
        last_request <= 1'b0;
        n_loads    = 0;
        n_reqs     = 0;
        n_settings = 0;
        calm_in    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every table entry first so no scan ever touches an unloaded one.
        for (int s = 0; s < 16; s++)
        begin
            send_item(CMD_LOAD, slot_t'(s), opening_sizes[s], 1'b0);
        end
        send_item(CMD_REQ, 4'd9, 16'd0, 1'b0);
        send_item(CMD_REQ, 4'd15, 16'd65535, 1'b1);
        send_item(CMD_REQ, 4'd0, 16'd65535, 1'b0);
        apply_setting(POL_BEST, 5'd16);
        send_item(CMD_REQ, 4'd3, 16'd300, 1'b0);
        send_item(CMD_REQ, 4'd0, 16'd0, 1'b1);
        apply_setting(POL_WORST, 5'd16);
        send_item(CMD_REQ, 4'd0, 16'd1, 1'b0);
        apply_setting(POL_SPARE, 5'd16);
        send_item(CMD_REQ, 4'd0, 16'd5, 1'b0);
        apply_setting(POL_FIRST, 5'd0);
        send_item(CMD_REQ, 4'd0, 16'd0, 1'b1);
        apply_setting(POL_WORST, 5'd31);
        send_item(CMD_REQ, 4'd0, 16'd2, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
            begin
                apply_setting(pol_t'($urandom_range(0, 3)), cfg_data_t'($urandom_range(1, 31)));
            end
            else
            begin
                apply_setting(phase_pol[p], phase_cnt[p]);
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    wait_drained();
                end
                send_random_item();
            end
        end

        wait_drained();
        repeat (HOLD_CYCLES) @(posedge clk);
        $display("Ran %0d loads and %0d requests: %0d allocated, %0d found no fit.",
                 n_loads, n_reqs, hits, misses);
        $display("Used %0d register settings: all four policy codes, scan counts 0 to 31.",
                 n_settings);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
